[hw/rtl/glcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package glcd_pkg;

  localparam int DIM_DEFAULT         = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS           = 16;
  localparam int EMIT_MAX            = 16;

  localparam logic [63:0] ACC_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

  localparam logic [15:0] ITER_LIMIT_RESET = 16'd1000;
  localparam logic [31:0] TOLERANCE_RESET  = 32'd4295;

  localparam logic [1:0] OP_LOAD_GRAM   = 2'd0;
  localparam logic [1:0] OP_LOAD_TARGET = 2'd1;
  localparam logic [1:0] OP_LOAD_START  = 2'd2;
  localparam logic [1:0] OP_RUN         = 2'd3;

  localparam logic [1:0] CFG_PENALTY    = 2'd0;
  localparam logic [1:0] CFG_WEAK_MODE  = 2'd1;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_CO_RD,
    S_CO_LD,
    S_K_CHK,
    S_K_RD,
    S_K_LD,
    S_MUL,
    S_K_ACC,
    S_THRESH,
    S_DIV,
    S_WB,
    S_CV_RD,
    S_CV_LD,
    S_CV_ADD,
    S_TOL_INIT,
    S_TOL,
    S_CHECK,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } glcd_state_t;

endpackage

`default_nettype wire

[hw/rtl/glcd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface glcd_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [3:0]        row;
  logic [3:0]        col;
  logic signed [31:0] value;
  modport source(output valid, operation, row, col, value, input ready);
  modport sink(input valid, operation, row, col, value, output ready);
endinterface

interface glcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface glcd_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic               last;
  logic               converged;
  logic [15:0]        sweeps_used;
  modport source(output valid, coef_index, coef_value, last, converged, sweeps_used,
                 input ready);
  modport sink(input valid, coef_index, coef_value, last, converged, sweeps_used,
               output ready);
endinterface

`default_nettype wire

[hw/rtl/glcd_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module glcd_div #(
  parameter int NW = 80,
  parameter int DW = 33,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot,
  output logic          ovf
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nsh;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] q;
  logic [DW:0]   rem_sh;
  logic          qbit;
  logic [DW-1:0] rem_next;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh   = {rem, nsh[NW-1]};
    qbit     = (rem_sh >= {1'b0, dreg});
    rem_next = qbit ? DW'(rem_sh - {1'b0, dreg}) : DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nsh  <= num;
        rem  <= '0;
        dreg <= den;
        q    <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        rem <= rem_next;
        nsh <= nsh << 1;
        q   <= {q[QW-2:0], qbit};
        ovf <= ovf | q[QW-1];
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

`default_nettype wire

[hw/rtl/gram_lasso_coordinate_descent.sv]
`timescale 1ns / 1ps
`default_nettype none

// lasso solver by cyclic coordinate descent over a stored gram matrix
// channels: cmd (load gram entry, load target entry, load start entry, run),
//   cfg (register writes, always ready), rsp (one coefficient per transaction)
// load transactions are taken one per cycle while the solver is idle and produce nothing
// a run drops cmd.ready until its last coefficient has been taken
// a run first saves the start vector, then sweeps; products are built from NCH
//   16-bit chunks of the shared multiplier operand (3 at 32 bits), and each
//   coordinate update waits on the bit-serial divider unless its result is
//   zero or saturated without a division
// convergence test multiplies by tolerance twice, one bit per cycle
// then min(DIM,16) results, one at a time
// rsp holds its transaction until ready; the solver waits meanwhile
// reset (synchronous) restores the register defaults and idles the block;
//   the matrix and vectors stay undefined until loaded
// a later run without new start loads begins from the previous result

module gram_lasso_coordinate_descent #(
  parameter int DIM         = glcd_pkg::DIM_DEFAULT,
  parameter int VALUE_WIDTH = glcd_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  glcd_cmd_if.sink     cmd,
  glcd_cfg_if.sink     cfg,
  glcd_rsp_if.source   rsp
);

  localparam int VW   = VALUE_WIDTH;
  localparam int FB   = glcd_pkg::FRAC_BITS;
  localparam int AW   = $clog2(DIM);
  localparam int KW   = $clog2(DIM + 1);
  localparam int GD   = DIM * DIM;
  localparam int GAW  = $clog2(GD);
  localparam int MW   = VW + 1;
  localparam int NCH  = (MW + 15) / 16;
  localparam int CHW  = $clog2(NCH + 1);
  localparam int MBW  = NCH * 16;
  localparam int PW   = MBW + MW;
  localparam int EW   = (PW > 64) ? PW : 64;
  localparam int SQW  = 2 * MW + $clog2(DIM) + 1;
  localparam int XW   = SQW + 32;
  localparam int CW   = SQW + 64;
  localparam int NW   = 64 + FB;
  localparam int QW   = VW + 1;
  localparam int EC   = (DIM < glcd_pkg::EMIT_MAX) ? DIM : glcd_pkg::EMIT_MAX;

  localparam logic signed [63:0] VMAX64 = $signed((64'd1 << (VW - 1)) - 64'd1);
  localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
  localparam logic signed [64:0] LIM65  = $signed({1'b0, glcd_pkg::ACC_LIM});
  localparam logic [QW-1:0] QLIM_POS = (QW'(1) << (VW - 1)) - QW'(1);
  localparam logic [QW-1:0] QLIM_NEG = QW'(1) << (VW - 1);
  localparam logic [VW-1:0] XMAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] XMIN = {1'b1, {(VW - 1){1'b0}}};

  glcd_pkg::glcd_state_t state, state_next;

  logic [30:0] penalty;
  logic        weak_mode;
  logic [15:0] iteration_limit;
  logic [31:0] tolerance;

  logic [KW-1:0]     j;
  logic [KW-1:0]     k;
  logic [15:0]       sweeps;
  logic              converged;
  logic signed [VW-1:0] diag;
  logic signed [64:0]   acc;
  logic [MW-1:0]     ma;
  logic [MBW-1:0]    mb;
  logic [PW-1:0]     prod;
  logic [CHW-1:0]    chunk;
  logic              mneg;
  logic              in_conv;
  logic              phase;
  logic [MW-1:0]     hold_prev;
  logic [SQW-1:0]    dsum;
  logic [SQW-1:0]    psum;
  logic [XW-1:0]     mcand;
  logic [CW-1:0]     ysum;
  logic [31:0]       tsh;
  logic [4:0]        tcnt;
  logic              tpass;
  logic signed [VW-1:0] xval;
  logic              dneg;

  logic signed [VW-1:0] gram_mem [GD];
  logic signed [VW-1:0] tgt_mem  [DIM];
  logic signed [VW-1:0] cur_mem  [DIM];
  logic signed [VW-1:0] prev_mem [DIM];
  logic signed [VW-1:0] gram_rd, tgt_rd, cur_rd, prev_rd;

  logic          gram_we, tgt_we, cur_we, prev_we;
  logic [GAW-1:0] gram_wa, gram_ra;
  logic [AW-1:0]  vec_wa, cur_wa;
  logic signed [VW-1:0] in_val, cur_wd;

  logic          cmd_fire;
  logic          row_ok, col_ok;
  logic signed [63:0] in_ext;

  logic          rsp_valid;
  logic [3:0]    rsp_index;
  logic signed [31:0] rsp_value;
  logic          rsp_last;
  logic          rsp_conv;
  logic [15:0]   rsp_sweeps;

  logic          div_start, div_done, div_ovf;
  logic [NW-1:0] div_num;
  logic [MW-1:0] div_den;
  logic [QW-1:0] div_q;

  // datapath helpers
  logic [MW+15:0]   mul_pp;
  logic [PW-1:0]    prod_next;
  logic signed [VW:0] gx, cx, px, dx;
  logic [MW-1:0]    gmag, cmag, pmag, dmag;
  logic [EW-1:0]    m_full;
  logic [63:0]      m_sat;
  logic signed [64:0] acc_sum, acc_clamped;
  logic signed [64:0] lam, num65;
  logic signed [VW+1:0] dext, den_s;
  logic          upper, lower, band_zero, tneg;
  logic [63:0]   un;
  logic [MW-1:0] ud;
  logic [QW-1:0] qsat;
  logic [CW-1:0] ysum_next;
  logic [CW-1:0] left;
  logic          conv_now;
  logic [15:0]   sweeps_inc;
  logic          k_last, j_last, chunk_last, emit_last;

  assign cmd_fire = cmd.valid & cmd.ready;
  assign cfg.ready = 1'b1;

  // input value clamp to the stored width
  always_comb begin
    in_ext = 64'(cmd.value);
    if (in_ext > VMAX64) begin
      in_val = VMAX64[VW-1:0];
    end else if (in_ext < VMIN64) begin
      in_val = VMIN64[VW-1:0];
    end else begin
      in_val = in_ext[VW-1:0];
    end
    row_ok  = (32'(cmd.row) < DIM);
    col_ok  = (32'(cmd.col) < DIM);
    gram_wa = GAW'(32'(cmd.row) * 32'(DIM) + 32'(cmd.col));
    vec_wa  = AW'(cmd.row);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      penalty         <= '0;
      weak_mode       <= 1'b0;
      iteration_limit <= glcd_pkg::ITER_LIMIT_RESET;
      tolerance       <= glcd_pkg::TOLERANCE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        glcd_pkg::CFG_PENALTY:    penalty <= cfg.data[30:0];
        glcd_pkg::CFG_WEAK_MODE:  weak_mode <= cfg.data[0];
        glcd_pkg::CFG_ITER_LIMIT: iteration_limit <= cfg.data[15:0];
        glcd_pkg::CFG_TOLERANCE:  tolerance <= cfg.data;
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (gram_we) gram_mem[gram_wa] <= in_val;
    gram_rd <= gram_mem[gram_ra];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[vec_wa] <= in_val;
    tgt_rd <= tgt_mem[j[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_rd <= cur_mem[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[k[AW-1:0]] <= cur_rd;
    prev_rd <= prev_mem[k[AW-1:0]];
  end

  // arithmetic
  always_comb begin
    k_last     = (k == KW'(DIM - 1));
    j_last     = (j == KW'(DIM - 1));
    chunk_last = (chunk == CHW'(NCH - 1));
    emit_last  = (k == KW'(EC - 1));

    mul_pp    = ma * mb[MBW-1 -: 16];
    prod_next = (prod << 16) + PW'(mul_pp);

    gx   = (VW + 1)'(gram_rd);
    cx   = (VW + 1)'(cur_rd);
    px   = (VW + 1)'(prev_rd);
    dx   = cx - px;
    gmag = gx[VW] ? MW'(-gx) : MW'(gx);
    cmag = cx[VW] ? MW'(-cx) : MW'(cx);
    pmag = px[VW] ? MW'(-px) : MW'(px);
    dmag = dx[VW] ? MW'(-dx) : MW'(dx);

    m_full = EW'(prod) >> FB;
    m_sat  = (m_full > EW'(glcd_pkg::ACC_LIM)) ? glcd_pkg::ACC_LIM : m_full[63:0];
    acc_sum = mneg ? acc + $signed({1'b0, m_sat}) : acc - $signed({1'b0, m_sat});
    if (acc_sum > LIM65) begin
      acc_clamped = LIM65;
    end else if (acc_sum < -LIM65) begin
      acc_clamped = -LIM65;
    end else begin
      acc_clamped = acc_sum;
    end

    lam   = $signed({34'd0, penalty});
    upper = (acc > lam);
    lower = (acc < -lam);
    if (upper) begin
      num65 = acc - lam;
    end else if (lower) begin
      num65 = acc + lam;
    end else begin
      num65 = (acc > 65'sd0) ? lam : -lam;
    end
    dext      = (VW + 2)'(diag);
    den_s     = (upper || lower) ? dext : (dext <<< 1);
    band_zero = !upper && !lower && !weak_mode;
    un        = num65[64] ? 64'(-num65) : 64'(num65);
    ud        = den_s[VW+1] ? MW'(-den_s) : MW'(den_s);
    tneg      = num65[64] ^ den_s[VW+1];

    if (dneg) begin
      qsat = (div_ovf || div_q > QLIM_NEG) ? QLIM_NEG : div_q;
    end else begin
      qsat = (div_ovf || div_q > QLIM_POS) ? QLIM_POS : div_q;
    end

    ysum_next  = (ysum << 1) + (tsh[31] ? CW'(mcand) : CW'(0));
    left       = (psum == '0) ? (CW'(dsum) << 32) : (CW'(dsum) << 64);
    conv_now   = (left < ysum);
    sweeps_inc = sweeps + 16'd1;

    div_num = {un, {FB{1'b0}}};
    div_den = ud;
  end

  glcd_div #(
    .NW(NW),
    .DW(MW),
    .QW(QW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q),
    .ovf  (div_ovf)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      glcd_pkg::S_IDLE:
        if (cmd_fire && cmd.operation == glcd_pkg::OP_RUN) state_next = glcd_pkg::S_COPY_RD;
      glcd_pkg::S_COPY_RD: state_next = glcd_pkg::S_COPY_WR;
      glcd_pkg::S_COPY_WR: begin
        if (!k_last) begin
          state_next = glcd_pkg::S_COPY_RD;
        end else if (iteration_limit == 16'd0) begin
          state_next = glcd_pkg::S_EMIT_RD;
        end else begin
          state_next = glcd_pkg::S_CO_RD;
        end
      end
      glcd_pkg::S_CO_RD: state_next = glcd_pkg::S_CO_LD;
      glcd_pkg::S_CO_LD: state_next = glcd_pkg::S_K_CHK;
      glcd_pkg::S_K_CHK: begin
        if (k == KW'(DIM)) begin
          state_next = glcd_pkg::S_THRESH;
        end else if (k != j) begin
          state_next = glcd_pkg::S_K_RD;
        end
      end
      glcd_pkg::S_K_RD: state_next = glcd_pkg::S_K_LD;
      glcd_pkg::S_K_LD: state_next = glcd_pkg::S_MUL;
      glcd_pkg::S_MUL:
        if (chunk_last) state_next = in_conv ? glcd_pkg::S_CV_ADD : glcd_pkg::S_K_ACC;
      glcd_pkg::S_K_ACC: state_next = glcd_pkg::S_K_CHK;
      glcd_pkg::S_THRESH: begin
        if (band_zero || un == 64'd0 || ud == '0) begin
          state_next = glcd_pkg::S_WB;
        end else begin
          state_next = glcd_pkg::S_DIV;
        end
      end
      glcd_pkg::S_DIV: if (div_done) state_next = glcd_pkg::S_WB;
      glcd_pkg::S_WB: state_next = j_last ? glcd_pkg::S_CV_RD : glcd_pkg::S_CO_RD;
      glcd_pkg::S_CV_RD: state_next = glcd_pkg::S_CV_LD;
      glcd_pkg::S_CV_LD: state_next = glcd_pkg::S_MUL;
      glcd_pkg::S_CV_ADD: begin
        if (!phase) begin
          state_next = glcd_pkg::S_MUL;
        end else begin
          state_next = k_last ? glcd_pkg::S_TOL_INIT : glcd_pkg::S_CV_RD;
        end
      end
      glcd_pkg::S_TOL_INIT: state_next = glcd_pkg::S_TOL;
      glcd_pkg::S_TOL: if (tcnt == 5'd31 && tpass) state_next = glcd_pkg::S_CHECK;
      glcd_pkg::S_CHECK: begin
        if (conv_now || sweeps_inc == iteration_limit) begin
          state_next = glcd_pkg::S_EMIT_RD;
        end else begin
          state_next = glcd_pkg::S_CO_RD;
        end
      end
      glcd_pkg::S_EMIT_RD: state_next = glcd_pkg::S_EMIT_LD;
      glcd_pkg::S_EMIT_LD: state_next = glcd_pkg::S_EMIT_WAIT;
      glcd_pkg::S_EMIT_WAIT:
        if (rsp.ready) state_next = emit_last ? glcd_pkg::S_IDLE : glcd_pkg::S_EMIT_RD;
      default: state_next = glcd_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd.ready = (state == glcd_pkg::S_IDLE);
    gram_we   = 1'b0;
    tgt_we    = 1'b0;
    cur_we    = 1'b0;
    prev_we   = 1'b0;
    cur_wa    = vec_wa;
    cur_wd    = in_val;
    div_start = 1'b0;
    gram_ra   = GAW'(32'(j) * 32'(DIM) + 32'(k));
    case (state)
      glcd_pkg::S_IDLE: begin
        if (cmd_fire) begin
          gram_we = (cmd.operation == glcd_pkg::OP_LOAD_GRAM) && row_ok && col_ok;
          tgt_we  = (cmd.operation == glcd_pkg::OP_LOAD_TARGET) && row_ok;
          cur_we  = (cmd.operation == glcd_pkg::OP_LOAD_START) && row_ok;
        end
      end
      glcd_pkg::S_CO_RD: gram_ra = GAW'(32'(j) * 32'(DIM) + 32'(j));
      glcd_pkg::S_COPY_WR: prev_we = 1'b1;
      glcd_pkg::S_CV_LD: prev_we = 1'b1;
      glcd_pkg::S_THRESH: div_start = !(band_zero || un == 64'd0 || ud == '0);
      glcd_pkg::S_WB: begin
        cur_we = 1'b1;
        cur_wa = j[AW-1:0];
        cur_wd = xval;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= glcd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      sweeps    <= '0;
      converged <= 1'b0;
    end else begin
      case (state)
        glcd_pkg::S_IDLE: begin
          k         <= '0;
          j         <= '0;
          sweeps    <= '0;
          converged <= 1'b0;
        end
        glcd_pkg::S_COPY_WR: k <= k_last ? '0 : k + 1'b1;
        glcd_pkg::S_CO_LD: begin
          acc  <= 65'(tgt_rd);
          diag <= gram_rd;
          k    <= '0;
        end
        glcd_pkg::S_K_CHK: if (k == j) k <= k + 1'b1;
        glcd_pkg::S_K_LD: begin
          ma      <= gmag;
          mb      <= MBW'(cmag);
          mneg    <= gx[VW] ^ cx[VW];
          prod    <= '0;
          chunk   <= '0;
          in_conv <= 1'b0;
        end
        glcd_pkg::S_MUL: begin
          prod  <= prod_next;
          mb    <= mb << 16;
          chunk <= chunk + 1'b1;
        end
        glcd_pkg::S_K_ACC: begin
          acc <= acc_clamped;
          k   <= k + 1'b1;
        end
        glcd_pkg::S_THRESH: begin
          dneg <= tneg;
          if (band_zero || un == 64'd0) begin
            xval <= '0;
          end else if (ud == '0) begin
            xval <= num65[64] ? XMIN : XMAX;
          end
        end
        glcd_pkg::S_DIV: if (div_done) xval <= dneg ? VW'(-qsat) : VW'(qsat);
        glcd_pkg::S_WB: begin
          if (j_last) begin
            j    <= '0;
            k    <= '0;
            dsum <= '0;
            psum <= '0;
          end else begin
            j <= j + 1'b1;
          end
        end
        glcd_pkg::S_CV_LD: begin
          ma        <= dmag;
          mb        <= MBW'(dmag);
          hold_prev <= pmag;
          phase     <= 1'b0;
          in_conv   <= 1'b1;
          prod      <= '0;
          chunk     <= '0;
        end
        glcd_pkg::S_CV_ADD: begin
          if (!phase) begin
            dsum  <= dsum + SQW'(prod[2*MW-1:0]);
            ma    <= hold_prev;
            mb    <= MBW'(hold_prev);
            phase <= 1'b1;
            prod  <= '0;
            chunk <= '0;
          end else begin
            psum <= psum + SQW'(prod[2*MW-1:0]);
            k    <= k_last ? '0 : k + 1'b1;
          end
        end
        glcd_pkg::S_TOL_INIT: begin
          mcand <= (psum == '0) ? XW'(1) : XW'(psum);
          ysum  <= '0;
          tsh   <= tolerance;
          tcnt  <= '0;
          tpass <= 1'b0;
        end
        glcd_pkg::S_TOL: begin
          tcnt <= tcnt + 5'd1;
          if (tcnt == 5'd31 && !tpass) begin
            mcand <= XW'(ysum_next);
            ysum  <= '0;
            tsh   <= tolerance;
            tpass <= 1'b1;
          end else begin
            ysum <= ysum_next;
            tsh  <= tsh << 1;
          end
        end
        glcd_pkg::S_CHECK: begin
          sweeps    <= sweeps_inc;
          converged <= conv_now;
          j         <= '0;
          k         <= '0;
        end
        glcd_pkg::S_EMIT_LD: begin
          rsp_valid  <= 1'b1;
          rsp_index  <= 4'(k);
          rsp_value  <= 32'(64'(cur_rd));
          rsp_last   <= emit_last;
          rsp_conv   <= converged;
          rsp_sweeps <= sweeps;
        end
        glcd_pkg::S_EMIT_WAIT: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
            k         <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.coef_index  = rsp_index;
  assign rsp.coef_value  = rsp_value;
  assign rsp.last        = rsp_last;
  assign rsp.converged   = rsp_conv;
  assign rsp.sweeps_used = rsp_sweeps;

endmodule

`default_nettype wire

[hw/rtl/glcd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module glcd_checker #(
  parameter int EMIT_LAST = glcd_pkg::EMIT_MAX - 1
) (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  rsp_coef_index,
  input logic        rsp_last,
  input logic        rsp_converged,
  input logic [15:0] rsp_sweeps_used
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_busy_while_emit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !cmd_ready)
    else $error("command taken during result transaction");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_last |-> rsp_coef_index == 4'(EMIT_LAST))
    else $error("last flag on wrong coefficient");

  a_conv_sweeps: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_converged |-> rsp_sweeps_used != 16'd0)
    else $error("converged without a sweep");

endmodule

bind gram_lasso_coordinate_descent glcd_checker #(
  .EMIT_LAST((DIM < glcd_pkg::EMIT_MAX) ? DIM - 1 : glcd_pkg::EMIT_MAX - 1)
) u_glcd_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_coef_index (rsp.coef_index),
  .rsp_last       (rsp.last),
  .rsp_converged  (rsp.converged),
  .rsp_sweeps_used(rsp.sweeps_used)
);

`default_nettype wire

[dv/tb_gram_lasso_coordinate_descent.sv]
`timescale 1ns / 1ps

module tb_gram_lasso_coordinate_descent;

  typedef struct packed {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
    logic        conv;
    logic [15:0] sweeps;
  } coef_t;

  typedef struct {
    bit          is_reg;
    logic [1:0]  code;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    bit          has_exp;
    logic [31:0] exp0;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  glcd_cmd_if cmd ();
  glcd_cfg_if cfg ();
  glcd_rsp_if rsp ();

  gram_lasso_coordinate_descent dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .cfg(cfg),
    .rsp(rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  longint      gram_m[256];
  longint      target_v[16];
  longint      coef_cur[16];
  longint      coef_prev[16];
  longint      pen_r;
  bit          weak_r;
  int unsigned limit_r;
  logic [63:0] tol_r;
  coef_t       coef_q[$];
  logic [31:0] run_first_coef;
  int          fails = 0;
  bit          busy_idle = 1'b1;
  step_t       steps[20];
  int          nsteps = 0;

  function automatic logic [63:0] mag(longint v);
    logic [63:0] u;
    u = v;
    return v < 0 ? -u : u;
  endfunction

  function automatic longint sat_acc(longint v);
    longint lim;
    lim = longint'(glcd_pkg::ACC_LIM);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] m;
    p = 128'(mag(a)) * 128'(mag(b));
    m = p >> glcd_pkg::FRAC_BITS;
    if (m > 128'(glcd_pkg::ACC_LIM)) m = 128'(glcd_pkg::ACC_LIM);
    return ((a < 0) != (b < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint q16_div(longint num, longint den);
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    if (num == 0) return 0;
    if (den == 0) return num < 0 ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    n = 128'(mag(num)) << glcd_pkg::FRAC_BITS;
    q = n / 128'(mag(den));
    if (q > lim) q = lim;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic bit sweep_converged();
    logic [255:0] d;
    logic [255:0] p;
    logic [255:0] x;
    logic [255:0] tt;
    d = '0;
    p = '0;
    for (int k = 0; k < 16; k++) begin
      x = 256'(mag(coef_cur[k] - coef_prev[k]));
      d += x * x;
      x = 256'(mag(coef_prev[k]));
      p += x * x;
    end
    tt = 256'(tol_r) * 256'(tol_r);
    if (p == 0) return (d << 32) < tt;
    return (d << 64) < (p * tt);
  endfunction

  function automatic void coord_sweep();
    longint acc;
    longint diag;
    for (int j = 0; j < 16; j++) begin
      acc = target_v[j];
      diag = gram_m[j * 16 + j];
      for (int k = 0; k < 16; k++) begin
        if (k != j) acc = sat_acc(acc - q16_mul(gram_m[j * 16 + k], coef_cur[k]));
      end
      if (acc > pen_r) coef_cur[j] = q16_div(acc - pen_r, diag);
      else if (acc < -pen_r) coef_cur[j] = q16_div(acc + pen_r, diag);
      else if (weak_r) coef_cur[j] = q16_div(acc > 0 ? pen_r : -pen_r, 2 * diag);
      else coef_cur[j] = 0;
    end
  endfunction

  function automatic void solve_lasso();
    int unsigned nsw;
    bit conv;
    coef_t c;
    coef_prev = coef_cur;
    nsw = 0;
    conv = 1'b0;
    while (nsw < limit_r) begin
      coord_sweep();
      nsw++;
      if (sweep_converged()) begin
        conv = 1'b1;
        break;
      end
      coef_prev = coef_cur;
    end
    run_first_coef = coef_cur[0][31:0];
    for (int k = 0; k < 16; k++) begin
      c.idx = k[3:0];
      c.val = coef_cur[k][31:0];
      c.last = (k == 15);
      c.conv = conv;
      c.sweeps = nsw[15:0];
      coef_q.push_back(c);
    end
  endfunction

  function automatic void apply_cmd(logic [1:0] op, logic [3:0] r, logic [3:0] c,
                                    logic [31:0] v);
    longint sv;
    sv = longint'($signed(v));
    case (op)
      glcd_pkg::OP_LOAD_GRAM: begin
        gram_m[r * 16 + c] = sv;
      end
      glcd_pkg::OP_LOAD_TARGET: begin
        target_v[r] = sv;
      end
      glcd_pkg::OP_LOAD_START: begin
        coef_cur[r] = sv;
      end
      default: begin
        solve_lasso();
      end
    endcase
  endfunction

  task automatic wait_drained();
    while (coef_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_cmd(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic [31:0] v);
    if (busy_idle && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.operation <= op;
    cmd.row <= r;
    cmd.col <= c;
    cmd.value <= v;
    do @(posedge clk); while (!cmd.ready);
    apply_cmd(op, r, c, v);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cmd.valid <= 1'b0;
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      glcd_pkg::CFG_PENALTY: pen_r = longint'(data[30:0]);
      glcd_pkg::CFG_WEAK_MODE: weak_r = data[0];
      glcd_pkg::CFG_ITER_LIMIT: limit_r = 32'(data[15:0]);
      default: tol_r = 64'(data);
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(logic [1:0] op, bit on_diag);
    if ($urandom_range(0, 6) == 0) return $urandom;
    if (op == glcd_pkg::OP_LOAD_GRAM && on_diag) return $urandom_range(32'h1_0000, 32'h8_0000);
    if (op == glcd_pkg::OP_LOAD_GRAM) return $urandom_range(0, 32'h8000) - 32'h4000;
    if (op == glcd_pkg::OP_LOAD_TARGET) return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [31:0] data);
    steps[nsteps] = '{1'b1, idx, 4'd0, 4'd0, data, 1'b0, 32'd0};
    nsteps++;
  endfunction

  function automatic void add_cmd(logic [1:0] op, logic [3:0] r, logic [3:0] c,
                                  logic [31:0] v, bit he, logic [31:0] e);
    steps[nsteps] = '{1'b0, op, r, c, v, he, e};
    nsteps++;
  endfunction

  initial begin
    forever begin
      if (busy_idle && $urandom_range(0, 1) == 0) rsp.ready <= 1'b0;
      else rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    coef_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (coef_q.size() == 0) begin
        $error("unexpected coefficient transaction, index %0d", rsp.coef_index);
        fails++;
      end else begin
        e = coef_q.pop_front();
        if (rsp.coef_index !== e.idx) begin
          $error("coef_index expected %0d actual %0d", e.idx, rsp.coef_index);
          fails++;
        end
        if (rsp.coef_value !== e.val) begin
          $error("coef_value expected %h actual %h", e.val, rsp.coef_value);
          fails++;
        end
        if (rsp.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, rsp.last);
          fails++;
        end
        if (rsp.converged !== e.conv) begin
          $error("converged expected %0d actual %0d", e.conv, rsp.converged);
          fails++;
        end
        if (rsp.sweeps_used !== e.sweeps) begin
          $error("sweeps_used expected %0d actual %0d", e.sweeps, rsp.sweeps_used);
          fails++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("tb_gram_lasso_coordinate_descent failed");
    $finish;
  end

  initial begin
    logic [1:0] op;
    logic [3:0] r;
    logic [3:0] c;
    int sent;
    int seg;
    cmd.valid <= 1'b0;
    cmd.operation <= glcd_pkg::OP_LOAD_GRAM;
    cmd.row <= '0;
    cmd.col <= '0;
    cmd.value <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= glcd_pkg::CFG_PENALTY;
    cfg.data <= '0;
    pen_r = 0;
    weak_r = 1'b0;
    limit_r = 32'(glcd_pkg::ITER_LIMIT_RESET);
    tol_r = 64'(glcd_pkg::TOLERANCE_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every store entry before the first run
    for (int i = 0; i < 256; i++) begin
      send_cmd(glcd_pkg::OP_LOAD_GRAM, i[7:4], i[3:0],
               pick_value(glcd_pkg::OP_LOAD_GRAM, i[7:4] == i[3:0]));
    end
    for (int i = 0; i < 16; i++) begin
      send_cmd(glcd_pkg::OP_LOAD_TARGET, i[3:0], 4'd0,
               pick_value(glcd_pkg::OP_LOAD_TARGET, 1'b0));
      send_cmd(glcd_pkg::OP_LOAD_START, i[3:0], 4'd0,
               pick_value(glcd_pkg::OP_LOAD_START, 1'b0));
    end

    // directed
    add_reg(glcd_pkg::CFG_ITER_LIMIT, 32'd0);
    add_cmd(glcd_pkg::OP_LOAD_START, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'd0);
    add_cmd(glcd_pkg::OP_LOAD_START, 4'd15, 4'd0, 32'h8000_0000, 1'b0, 32'd0);
    add_cmd(glcd_pkg::OP_RUN, 4'd0, 4'd0, 32'd0, 1'b1, 32'h7FFF_FFFF);
    add_reg(glcd_pkg::CFG_PENALTY, 32'hFFFF_FFFF);
    add_reg(glcd_pkg::CFG_TOLERANCE, 32'hFFFF_FFFF);
    add_reg(glcd_pkg::CFG_ITER_LIMIT, 32'd16);
    add_cmd(glcd_pkg::OP_RUN, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'd0);
    add_reg(glcd_pkg::CFG_ITER_LIMIT, 32'd1);
    add_reg(glcd_pkg::CFG_WEAK_MODE, 32'd1);
    add_cmd(glcd_pkg::OP_LOAD_GRAM, 4'd3, 4'd3, 32'd0, 1'b0, 32'd0);
    add_cmd(glcd_pkg::OP_LOAD_TARGET, 4'd5, 4'd0, 32'd0, 1'b0, 32'd0);
    add_cmd(glcd_pkg::OP_RUN, 4'd0, 4'd0, 32'd0, 1'b0, 32'd0);
    add_reg(glcd_pkg::CFG_PENALTY, 32'd0);
    add_reg(glcd_pkg::CFG_TOLERANCE, 32'd0);
    add_cmd(glcd_pkg::OP_LOAD_GRAM, 4'd0, 4'd0, 32'd0, 1'b0, 32'd0);
    add_cmd(glcd_pkg::OP_LOAD_TARGET, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'd0);
    add_cmd(glcd_pkg::OP_RUN, 4'd0, 4'd0, 32'd0, 1'b0, 32'd0);
    add_reg(glcd_pkg::CFG_WEAK_MODE, 32'hFFFF_FFFE);
    add_cmd(glcd_pkg::OP_LOAD_GRAM, 4'd0, 4'd0, 32'h0001_0000, 1'b0, 32'd0);
    for (int i = 0; i < nsteps; i++) begin
      if (steps[i].is_reg) begin
        write_reg(steps[i].code, steps[i].value);
      end else begin
        send_cmd(steps[i].code, steps[i].row, steps[i].col, steps[i].value);
        if (steps[i].has_exp && run_first_coef !== steps[i].exp0) begin
          $error("coef_value expected %h actual %h", steps[i].exp0, run_first_coef);
          fails++;
        end
      end
    end
    cmd.valid <= 1'b0;
    wait_drained();

    // random segments of loads closed by a run
    sent = 0;
    seg = 0;
    while (sent < 170) begin
      if (seg % 3 == 0) begin
        write_reg(glcd_pkg::CFG_PENALTY,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h2_0000));
        write_reg(glcd_pkg::CFG_WEAK_MODE, $urandom);
        write_reg(glcd_pkg::CFG_ITER_LIMIT, $urandom_range(1, 4));
        write_reg(glcd_pkg::CFG_TOLERANCE,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h10_0000));
      end
      if (sent > 130) busy_idle = 1'b0;
      repeat ($urandom_range(6, 14)) begin
        op = $urandom_range(0, 9) < 6 ? glcd_pkg::OP_LOAD_GRAM : 2'($urandom_range(1, 2));
        r = 4'($urandom);
        c = $urandom_range(0, 2) == 0 ? r : 4'($urandom);
        if ($urandom_range(0, 25) == 0) op = glcd_pkg::OP_RUN;
        send_cmd(op, r, c, pick_value(op, r == c));
        sent++;
      end
      send_cmd(glcd_pkg::OP_RUN, 4'($urandom), 4'($urandom), $urandom);
      sent++;
      seg++;
      if (seg == 5) begin
        cmd.valid <= 1'b0;
        wait_drained();
      end
    end
    cmd.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb_gram_lasso_coordinate_descent passed");
    end else begin
      $display("tb_gram_lasso_coordinate_descent failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/glcd_pkg.sv
hw/rtl/glcd_if.sv
hw/rtl/glcd_div.sv
hw/rtl/gram_lasso_coordinate_descent.sv
hw/rtl/glcd_checker.sv
dv/tb_gram_lasso_coordinate_descent.sv
